/* src/assert_macros.svh */
// Assertion helpers for the files that check their own logic.
// Both expect i_clk and i_rst_n to be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// A condition that must never be true outside reset.
`define TCS_NEVER(label, cond, msg) \
    `TCS_ASSERT(label, !(cond), msg)

`endif

/* src/tcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task scheduler package
// Shared constants, transaction types and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tcs_pkg;

    // Parameter defaults.
    localparam int MAX_TASKS_DEF = 8;
    localparam int SUBTICKS_DEF  = 250;

    // Command codes of an input transaction.
    typedef enum logic [2:0] {
        CMD_CREATE_SYS = 3'd0,
        CMD_CREATE_RR  = 3'd1,
        CMD_CREATE_PER = 3'd2,
        CMD_YIELD      = 3'd3,
        CMD_TERMINATE  = 3'd4,
        CMD_TICK       = 3'd5
    } t_cmd;

    // Task classes held in the task table.
    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_RR   = 2'd1,
        CLS_PER  = 2'd2,
        CLS_SYS  = 2'd3
    } t_cls;

    // Input transaction.
    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] task_period;
        logic [15:0] task_budget;
        logic [15:0] task_phase;
        logic [7:0]  subtick_now;
    } t_in_item;

    // Result transaction.
    typedef struct packed {
        logic [3:0]  created_pid;
        logic [3:0]  running_pid;
        logic        switched;
        logic        table_full;
        logic        queue_overflow;
        logic        periodic_overlap;
        logic        periodic_collision;
        logic        budget_overrun;
        logic        idle_waiting;
        logic        no_task_left;
        logic [15:0] tick_now;
    } t_out_item;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_CREATE,
        OP_REQUEUE,
        OP_SETWAIT,
        OP_FREE,
        OP_TICK,
        OP_SREAD,
        OP_SDIV,
        OP_SEVAL,
        OP_CREAD,
        OP_CMUL1,
        OP_CMUL2,
        OP_CRED,
        OP_CDIV,
        OP_CEVAL,
        OP_DISPATCH,
        OP_OUTLOAD
    } t_dp_op;

    // Status returned by the datapath to the controller.
    typedef struct packed {
        logic [2:0] cmd;
        t_cls       run_cls;
        logic       running_nz;
        logic       free_any;
        logic       waiting_nz;
        logic       scan_last;
        logic       sdiv_go;
        logic       div_done;
        logic       q_nz;
    } t_dp_status;

endpackage

/* src/tcs_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcs_div #(
    parameter int DW = 17,
    parameter int VW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [VW-1:0] o_rem
);
    localparam int CNTW = $clog2(DW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_quo;
    logic [VW-1:0]   r_rem;
    logic [VW-1:0]   r_div;

    logic [VW:0]     trial;
    logic            ge;
    logic [VW-1:0]   n_rem;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? VW'(trial - {1'b0, r_div}) : trial[VW-1:0];
    end

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* src/tcs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences one command transaction through the datapath operations.
// ----------------------------------------------------------------------------
module tcs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  tcs_pkg::t_dp_status i_status,
    output tcs_pkg::t_dp_op     o_op
);
    typedef enum logic [21:0] {
        ST_IDLE   = 22'h000001,
        ST_DECODE = 22'h000002,
        ST_CREATE = 22'h000004,
        ST_REQ    = 22'h000008,
        ST_SETW   = 22'h000010,
        ST_FREE   = 22'h000020,
        ST_TINC   = 22'h000040,
        ST_SREAD  = 22'h000080,
        ST_SDIV   = 22'h000100,
        ST_SWAIT  = 22'h000200,
        ST_SEVAL  = 22'h000400,
        ST_POST   = 22'h000800,
        ST_CREAD  = 22'h001000,
        ST_CMUL1  = 22'h002000,
        ST_CMUL2  = 22'h004000,
        ST_CRED   = 22'h008000,
        ST_CDIV   = 22'h010000,
        ST_CEVAL  = 22'h040000,
        ST_DISP   = 22'h080000,
        ST_TAIL   = 22'h100000,
        ST_FIN    = 22'h200000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Next state, datapath operation and result valid.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_op        = tcs_pkg::OP_NONE;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_op    = tcs_pkg::OP_CAPTURE;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_status.cmd) inside
                    tcs_pkg::CMD_CREATE_SYS, tcs_pkg::CMD_CREATE_RR,
                    tcs_pkg::CMD_CREATE_PER: n_state = ST_CREATE;
                    tcs_pkg::CMD_YIELD:      n_state = i_status.running_nz ? ST_REQ : ST_TAIL;
                    tcs_pkg::CMD_TERMINATE:  n_state = i_status.running_nz ? ST_FREE : ST_TAIL;
                    tcs_pkg::CMD_TICK:       n_state = ST_TINC;
                    default:                 n_state = ST_TAIL;
                endcase
            end
            ST_CREATE: begin
                // A new system task preempts a running round-robin or periodic task.
                o_op = tcs_pkg::OP_CREATE;
                if (i_status.cmd == tcs_pkg::CMD_CREATE_SYS && i_status.free_any &&
                    i_status.run_cls == tcs_pkg::CLS_RR) begin
                    n_state = ST_REQ;
                end else if (i_status.cmd == tcs_pkg::CMD_CREATE_SYS && i_status.free_any &&
                             i_status.run_cls == tcs_pkg::CLS_PER) begin
                    n_state = ST_SETW;
                end else begin
                    n_state = ST_TAIL;
                end
            end
            ST_REQ: begin
                o_op    = tcs_pkg::OP_REQUEUE;
                n_state = ST_DISP;
            end
            ST_SETW: begin
                o_op    = tcs_pkg::OP_SETWAIT;
                n_state = ST_DISP;
            end
            ST_FREE: begin
                o_op    = tcs_pkg::OP_FREE;
                n_state = ST_DISP;
            end
            ST_TINC: begin
                o_op    = tcs_pkg::OP_TICK;
                n_state = ST_SREAD;
            end
            ST_SREAD: begin
                o_op    = tcs_pkg::OP_SREAD;
                n_state = ST_SDIV;
            end
            ST_SDIV: begin
                o_op    = tcs_pkg::OP_SDIV;
                n_state = i_status.sdiv_go ? ST_SWAIT : ST_SEVAL;
            end
            ST_SWAIT: begin
                if (i_status.div_done) begin
                    n_state = ST_SEVAL;
                end
            end
            ST_SEVAL: begin
                o_op    = tcs_pkg::OP_SEVAL;
                n_state = i_status.scan_last ? ST_POST : ST_SREAD;
            end
            ST_POST: begin
                if (i_status.waiting_nz) begin
                    n_state = ST_REQ;
                end else if (i_status.running_nz) begin
                    n_state = ST_CREAD;
                end else begin
                    n_state = ST_TAIL;
                end
            end
            ST_CREAD: begin
                o_op    = tcs_pkg::OP_CREAD;
                n_state = ST_CMUL1;
            end
            ST_CMUL1: begin
                o_op    = tcs_pkg::OP_CMUL1;
                n_state = ST_CMUL2;
            end
            ST_CMUL2: begin
                o_op    = tcs_pkg::OP_CMUL2;
                n_state = ST_CRED;
            end
            ST_CRED: begin
                o_op    = tcs_pkg::OP_CRED;
                n_state = ST_CDIV;
            end
            ST_CDIV: begin
                // The budget limit in sub-ticks is formed here.
                o_op    = tcs_pkg::OP_CDIV;
                n_state = ST_CEVAL;
            end
            ST_CEVAL: begin
                // An expired slice puts a non-periodic task back.
                o_op = tcs_pkg::OP_CEVAL;
                if (i_status.q_nz && i_status.run_cls != tcs_pkg::CLS_PER) begin
                    n_state = ST_REQ;
                end else begin
                    n_state = ST_TAIL;
                end
            end
            ST_DISP: begin
                o_op    = tcs_pkg::OP_DISPATCH;
                n_state = ST_FIN;
            end
            ST_TAIL: begin
                // A step that ends idle without a dispatch makes one.
                n_state = i_status.running_nz ? ST_FIN : ST_DISP;
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_op        = tcs_pkg::OP_OUTLOAD;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State and result valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* src/tcs_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler datapath
// Task table, ready queues, tick counter, slice arithmetic and result register.
// ----------------------------------------------------------------------------
module tcs_dp #(
    parameter int MAX_TASKS = tcs_pkg::MAX_TASKS_DEF,
    parameter int SUBTICKS  = tcs_pkg::SUBTICKS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcs_pkg::t_dp_op     i_op,
    input  tcs_pkg::t_in_item   i_in_item,
    output tcs_pkg::t_dp_status o_status,
    output tcs_pkg::t_out_item  o_out_item
);
    localparam int IW  = $clog2(MAX_TASKS);
    localparam int PW  = $clog2(MAX_TASKS + 1);
    localparam int SPW = PW + 1;
    localparam int SW  = $clog2(SUBTICKS + 1);
    localparam int DW  = 16 + SW + 1;
    localparam int TW  = 17;
    localparam logic [DW-1:0] SubK = DW'(SUBTICKS);
    localparam logic [DW-1:0] ModV = SubK << 16;

    // Captured command fields.
    logic [2:0]  r_cmd;
    logic [7:0]  r_sub;
    logic [15:0] r_in_period, r_in_budget, r_in_phase;

    // Task table and queues.
    logic [MAX_TASKS-1:0] r_used;
    tcs_pkg::t_cls        r_cls [MAX_TASKS];
    logic [15:0]          r_mem_period [MAX_TASKS];
    logic [15:0]          r_mem_phase [MAX_TASKS];
    logic [15:0]          r_mem_budget [MAX_TASKS];
    logic [15:0]          r_mem_start_tick [MAX_TASKS];
    logic [7:0]           r_mem_start_sub [MAX_TASKS];
    logic [IW-1:0]        r_sys_fifo [MAX_TASKS];
    logic [IW-1:0]        r_rr_fifo [MAX_TASKS];
    logic [IW-1:0]        r_sys_head, r_rr_head;
    logic [PW-1:0]        r_sys_cnt, r_rr_cnt;
    logic [PW-1:0]        r_waiting, r_running;
    tcs_pkg::t_cls        r_run_cls;
    logic [15:0]          r_tick;

    // Per-step flags.
    logic [PW-1:0] r_created;
    logic r_full, r_ovf, r_overlap, r_coll, r_over, r_idle_wait, r_none_left, r_sw;

    // Scan and slice working registers.
    logic [IW-1:0] r_idx;
    logic          r_elig;
    logic [15:0]   r_rd_period, r_rd_phase, r_rd_budget, r_rd_start_tick;
    logic [7:0]    r_rd_start_sub;
    logic [DW-1:0] r_now, r_then, r_lim;
    tcs_pkg::t_out_item r_out;

    // Combinational helpers.
    logic          alloc_found;
    logic [IW-1:0] alloc_idx;
    tcs_pkg::t_cls new_cls;
    logic          any_per;
    logic [IW-1:0] run_idx;
    logic          push_sys, push_rr;
    logic [IW-1:0] push_val;
    logic          sys_full, rr_full;
    logic [IW-1:0] sys_pos, rr_pos;
    logic          pop_sys, pop_rr, disp_found;
    logic [IW-1:0] disp_idx;
    tcs_pkg::t_cls disp_cls;
    logic          sdiv_go;
    logic          div_start, div_done;
    logic [TW-1:0] div_dividend;
    logic [15:0]   div_divisor, div_rem;
    logic [DW-1:0] diff;
    logic          q_nz;

    function automatic logic [IW-1:0] f_wrap(input logic [IW-1:0] h, input logic [PW-1:0] c);
        logic [SPW-1:0] s;
        s = SPW'(h) + SPW'(c);
        if (s >= SPW'(MAX_TASKS)) begin
            s = s - SPW'(MAX_TASKS);
        end
        return s[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] h);
        return (h == IW'(MAX_TASKS - 1)) ? '0 : h + IW'(1);
    endfunction

    // Lowest free slot and the periodic presence check.
    always_comb begin
        alloc_found = 1'b0;
        alloc_idx   = '0;
        any_per     = 1'b0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                alloc_found = 1'b1;
                alloc_idx   = IW'(i);
            end
            if (r_used[i] && r_cls[i] == tcs_pkg::CLS_PER) begin
                any_per = 1'b1;
            end
        end
    end

    always_comb begin
        if (r_cmd == tcs_pkg::CMD_CREATE_SYS) begin
            new_cls = tcs_pkg::CLS_SYS;
        end else if (r_cmd == tcs_pkg::CMD_CREATE_RR) begin
            new_cls = tcs_pkg::CLS_RR;
        end else begin
            new_cls = tcs_pkg::CLS_PER;
        end
    end

    assign run_idx = IW'(r_running - PW'(1));

    // Queue pushes from creation and from putting the running task back.
    always_comb begin
        push_sys = 1'b0;
        push_rr  = 1'b0;
        push_val = alloc_idx;
        if (i_op == tcs_pkg::OP_CREATE && alloc_found) begin
            push_sys = (r_cmd == tcs_pkg::CMD_CREATE_SYS);
            push_rr  = (r_cmd == tcs_pkg::CMD_CREATE_RR);
        end else if (i_op == tcs_pkg::OP_REQUEUE) begin
            push_val = run_idx;
            push_sys = (r_run_cls == tcs_pkg::CLS_SYS);
            push_rr  = (r_run_cls == tcs_pkg::CLS_RR);
        end
    end

    assign sys_full = (r_sys_cnt == PW'(MAX_TASKS));
    assign rr_full  = (r_rr_cnt == PW'(MAX_TASKS));
    assign sys_pos  = f_wrap(r_sys_head, r_sys_cnt);
    assign rr_pos   = f_wrap(r_rr_head, r_rr_cnt);

    // Dispatch selection: system queue, then the waiting periodic task, then round robin.
    always_comb begin
        pop_sys    = 1'b0;
        pop_rr     = 1'b0;
        disp_found = 1'b1;
        disp_idx   = '0;
        disp_cls   = tcs_pkg::CLS_NONE;
        if (r_sys_cnt != '0) begin
            pop_sys  = (i_op == tcs_pkg::OP_DISPATCH);
            disp_idx = r_sys_fifo[r_sys_head];
            disp_cls = tcs_pkg::CLS_SYS;
        end else if (r_waiting != '0) begin
            disp_idx = IW'(r_waiting - PW'(1));
            disp_cls = tcs_pkg::CLS_PER;
        end else if (r_rr_cnt != '0) begin
            pop_rr   = (i_op == tcs_pkg::OP_DISPATCH);
            disp_idx = r_rr_fifo[r_rr_head];
            disp_cls = tcs_pkg::CLS_RR;
        end else begin
            disp_found = 1'b0;
        end
    end

    // Release test operands and divider feed; the slice length is compared in
    // sub-ticks, so a whole tick has passed once the difference reaches SUBTICKS.
    assign sdiv_go = r_used[r_idx] && (r_cls[r_idx] == tcs_pkg::CLS_PER) &&
                     (r_rd_period != '0) && (r_tick > r_rd_phase);
    assign diff = (r_now >= r_then) ? (r_now - r_then) : (r_now + ModV - r_then);
    assign div_start    = (i_op == tcs_pkg::OP_SDIV) && sdiv_go;
    assign div_dividend = TW'(r_tick) + TW'(r_rd_phase);
    assign div_divisor  = r_rd_period;
    assign q_nz         = (diff >= SubK);

    tcs_div #(
        .DW (TW),
        .VW (16)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Scheduler control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_cls[i] <= tcs_pkg::CLS_NONE;
            end
            r_sys_head  <= '0;
            r_sys_cnt   <= '0;
            r_rr_head   <= '0;
            r_rr_cnt    <= '0;
            r_waiting   <= '0;
            r_running   <= '0;
            r_run_cls   <= tcs_pkg::CLS_NONE;
            r_tick      <= '0;
            r_created   <= '0;
            r_full      <= 1'b0;
            r_ovf       <= 1'b0;
            r_overlap   <= 1'b0;
            r_coll      <= 1'b0;
            r_over      <= 1'b0;
            r_idle_wait <= 1'b0;
            r_none_left <= 1'b0;
            r_sw        <= 1'b0;
            r_idx       <= '0;
            r_elig      <= 1'b0;
        end else begin
            unique case (i_op)
                tcs_pkg::OP_CAPTURE: begin
                    r_created   <= '0;
                    r_full      <= 1'b0;
                    r_ovf       <= 1'b0;
                    r_overlap   <= 1'b0;
                    r_coll      <= 1'b0;
                    r_over      <= 1'b0;
                    r_idle_wait <= 1'b0;
                    r_none_left <= 1'b0;
                    r_sw        <= 1'b0;
                end
                tcs_pkg::OP_CREATE: begin
                    if (alloc_found) begin
                        r_used[alloc_idx] <= 1'b1;
                        r_cls[alloc_idx]  <= new_cls;
                        r_created         <= PW'(alloc_idx) + PW'(1);
                    end else begin
                        r_full <= 1'b1;
                    end
                end
                tcs_pkg::OP_SETWAIT: r_waiting <= r_running;
                tcs_pkg::OP_FREE: begin
                    r_used[run_idx] <= 1'b0;
                    r_running       <= '0;
                    r_run_cls       <= tcs_pkg::CLS_NONE;
                end
                tcs_pkg::OP_TICK: begin
                    r_tick <= r_tick + 16'd1;
                    r_idx  <= '0;
                end
                tcs_pkg::OP_SDIV: r_elig <= sdiv_go;
                tcs_pkg::OP_SEVAL: begin
                    // A release waits if no periodic task waits or runs; otherwise it only flags.
                    if (r_elig && div_rem == '0) begin
                        if (r_waiting != '0) begin
                            r_overlap <= 1'b1;
                        end else if (r_run_cls == tcs_pkg::CLS_PER) begin
                            r_coll <= 1'b1;
                        end else begin
                            r_waiting <= PW'(r_idx) + PW'(1);
                        end
                    end
                    if (r_idx != IW'(MAX_TASKS - 1)) begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                tcs_pkg::OP_CEVAL: begin
                    // More whole ticks than the budget means the difference
                    // reaches (budget + 1) * SUBTICKS.
                    if (q_nz && r_run_cls == tcs_pkg::CLS_PER && diff >= r_lim) begin
                        r_over <= 1'b1;
                    end
                end
                tcs_pkg::OP_DISPATCH: begin
                    r_sw <= 1'b1;
                    if (disp_found) begin
                        r_running <= PW'(disp_idx) + PW'(1);
                        r_run_cls <= disp_cls;
                        if (disp_cls == tcs_pkg::CLS_PER) begin
                            r_waiting <= '0;
                        end
                    end else begin
                        r_running   <= '0;
                        r_run_cls   <= tcs_pkg::CLS_NONE;
                        r_idle_wait <= any_per;
                        r_none_left <= !any_per;
                    end
                end
                default: ;
            endcase

            // Queue occupancy.
            if (push_sys) begin
                if (sys_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_sys_cnt <= r_sys_cnt + PW'(1);
                end
            end
            if (push_rr) begin
                if (rr_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_rr_cnt <= r_rr_cnt + PW'(1);
                end
            end
            if (pop_sys) begin
                r_sys_cnt  <= r_sys_cnt - PW'(1);
                r_sys_head <= f_next(r_sys_head);
            end
            if (pop_rr) begin
                r_rr_cnt  <= r_rr_cnt - PW'(1);
                r_rr_head <= f_next(r_rr_head);
            end
        end
    end

    // Slot parameter and start-time memories, queue storage.
    always_ff @(posedge i_clk) begin
        if (i_op == tcs_pkg::OP_CREATE && alloc_found && r_cmd == tcs_pkg::CMD_CREATE_PER) begin
            r_mem_period[alloc_idx] <= r_in_period;
            r_mem_phase[alloc_idx]  <= r_in_phase;
            r_mem_budget[alloc_idx] <= r_in_budget;
        end
        if (i_op == tcs_pkg::OP_SREAD) begin
            r_rd_period <= r_mem_period[r_idx];
            r_rd_phase  <= r_mem_phase[r_idx];
        end
        if (i_op == tcs_pkg::OP_DISPATCH && disp_found) begin
            r_mem_start_tick[disp_idx] <= r_tick;
            r_mem_start_sub[disp_idx]  <= r_sub;
        end
        if (i_op == tcs_pkg::OP_CREAD) begin
            r_rd_start_tick <= r_mem_start_tick[run_idx];
            r_rd_start_sub  <= r_mem_start_sub[run_idx];
            r_rd_budget     <= r_mem_budget[run_idx];
        end
        if (push_sys && !sys_full) begin
            r_sys_fifo[sys_pos] <= push_val;
        end
        if (push_rr && !rr_full) begin
            r_rr_fifo[rr_pos] <= push_val;
        end
    end

    // Captured inputs, slice arithmetic and result register.
    always_ff @(posedge i_clk) begin
        if (i_op == tcs_pkg::OP_CAPTURE) begin
            r_cmd       <= i_in_item.command;
            r_sub       <= i_in_item.subtick_now;
            r_in_period <= i_in_item.task_period;
            r_in_budget <= i_in_item.task_budget;
            r_in_phase  <= i_in_item.task_phase;
        end
        // Sub-tick timestamps, each reduced once below the wrap modulus.
        if (i_op == tcs_pkg::OP_CMUL1) begin
            r_now <= DW'(r_tick) * SubK + DW'(r_sub);
        end
        if (i_op == tcs_pkg::OP_CMUL2) begin
            r_then <= DW'(r_rd_start_tick) * SubK + DW'(r_rd_start_sub);
            r_now  <= (r_now >= ModV) ? (r_now - ModV) : r_now;
        end
        if (i_op == tcs_pkg::OP_CRED) begin
            r_then <= (r_then >= ModV) ? (r_then - ModV) : r_then;
        end
        // Budget limit in sub-ticks.
        if (i_op == tcs_pkg::OP_CDIV) begin
            r_lim <= (DW'(r_rd_budget) + DW'(1)) * SubK;
        end
        if (i_op == tcs_pkg::OP_OUTLOAD) begin
            r_out.created_pid        <= 4'(r_created);
            r_out.running_pid        <= 4'(r_running);
            r_out.switched           <= r_sw;
            r_out.table_full         <= r_full;
            r_out.queue_overflow     <= r_ovf;
            r_out.periodic_overlap   <= r_overlap;
            r_out.periodic_collision <= r_coll;
            r_out.budget_overrun     <= r_over;
            r_out.idle_waiting       <= r_idle_wait;
            r_out.no_task_left       <= r_none_left;
            r_out.tick_now           <= r_tick;
        end
    end

    // Status to the controller.
    always_comb begin
        o_status.cmd        = r_cmd;
        o_status.run_cls    = r_run_cls;
        o_status.running_nz = (r_running != '0);
        o_status.free_any   = alloc_found;
        o_status.waiting_nz = (r_waiting != '0);
        o_status.scan_last  = (r_idx == IW'(MAX_TASKS - 1));
        o_status.sdiv_go    = sdiv_go;
        o_status.div_done   = div_done;
        o_status.q_nz       = q_nz;
    end

    assign o_out_item = r_out;

endmodule

/* src/three_class_task_scheduler.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Three-class task scheduler
// System, periodic and round-robin task dispatch driven by command transactions.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  in       input      i_in_valid / o_in_ready   i_in_item  (t_in_item)
//  out      output     o_out_valid / i_out_ready o_out_item (t_out_item)
//
// Create, yield and terminate go through decode, their own table step and, where
// needed, a dispatch before the result is loaded. A tick reads, tests and
// evaluates each task slot in turn, with the serial 17-bit modulo for each
// releasable periodic slot, then does the slice check and any dispatch.
// The slice check compares sub-tick differences and needs no divider.
// Reset is synchronous; the task table needs no clearing pass.
// A finished result waits in the output register; the next transaction is
// taken once the controller is back in its idle state.
// ----------------------------------------------------------------------------
module three_class_task_scheduler #(
    parameter int MAX_TASKS         = tcs_pkg::MAX_TASKS_DEF,
    parameter int SUBTICKS_PER_TICK = tcs_pkg::SUBTICKS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tcs_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tcs_pkg::t_out_item o_out_item
);
    tcs_pkg::t_dp_op     dp_op;
    tcs_pkg::t_dp_status dp_status;

    // Command sequencer.
    tcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_op        (dp_op)
    );

    // Task table, queues and arithmetic.
    tcs_dp #(
        .MAX_TASKS (MAX_TASKS),
        .SUBTICKS  (SUBTICKS_PER_TICK)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (dp_op),
        .i_in_item  (i_in_item),
        .o_status   (dp_status),
        .o_out_item (o_out_item)
    );

    // Checks on the step sequencing and the result flags.
    `TCS_ASSERT(a_busy_after_accept, (i_in_valid && o_in_ready) |=> !o_in_ready, "second transaction taken while busy")
    `TCS_NEVER(a_idle_flags_excl, o_out_valid && o_out_item.idle_waiting && o_out_item.no_task_left, "both idle flags set")
    `TCS_ASSERT(a_idle_is_dispatch, (o_out_valid && (o_out_item.idle_waiting || o_out_item.no_task_left)) |-> (o_out_item.switched && o_out_item.running_pid == 4'd0), "idle result without a dispatch")
    `TCS_ASSERT(a_full_no_pid, (o_out_valid && o_out_item.table_full) |-> (o_out_item.created_pid == 4'd0), "table full with a created task")

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-class task scheduler testbench
// Drives command transactions through the input channel, predicts each result
// with a behavioral model of the task table and queues, and checks every
// result transaction field by field with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NSLOT = 8;
    localparam int SUBT  = 250;
    localparam longint CYCLE_LIMIT = 2_000_000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    tcs_pkg::t_in_item  i_in_item = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    tcs_pkg::t_out_item o_out_item;

    three_class_task_scheduler uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item)
    );

    always #4 i_clk = ~i_clk;

    // Scheduler state as predicted by the testbench.
    logic [NSLOT-1:0] sl_used;
    tcs_pkg::t_cls    sl_cls   [NSLOT];
    logic [15:0]      sl_per   [NSLOT];
    logic [15:0]      sl_ph    [NSLOT];
    logic [15:0]      sl_bud   [NSLOT];
    logic [15:0]      sl_t0    [NSLOT];
    logic [7:0]       sl_s0    [NSLOT];
    int               sys_q[$];
    int               rr_q[$];
    int               per_wait;
    int               cur_run;
    logic [15:0]      ticks;
    bit               ovf_f, idlew_f, none_f;

    tcs_pkg::t_out_item expected_results[$];
    bit        failed = 1'b0;
    bit        quiet = 1'b0;
    longint    cycles = 0;

    function automatic tcs_pkg::t_cls class_of(int pid);
        return (pid == 0) ? tcs_pkg::CLS_NONE : sl_cls[pid-1];
    endfunction

    function automatic void enqueue(tcs_pkg::t_cls c, int slot);
        if (c == tcs_pkg::CLS_SYS) begin
            if (sys_q.size() < NSLOT) sys_q.push_back(slot); else ovf_f = 1'b1;
        end else if (c == tcs_pkg::CLS_RR) begin
            if (rr_q.size() < NSLOT) rr_q.push_back(slot); else ovf_f = 1'b1;
        end
    endfunction

    function automatic void pick_next(logic [7:0] sub);
        int nxt;
        bit anyp;
        nxt = 0;
        anyp = 1'b0;
        if (sys_q.size() > 0) nxt = sys_q.pop_front() + 1;
        else if (per_wait != 0) begin
            nxt = per_wait;
            per_wait = 0;
        end else if (rr_q.size() > 0) nxt = rr_q.pop_front() + 1;
        if (nxt == 0) begin
            cur_run = 0;
            for (int i = 0; i < NSLOT; i++)
                if (sl_used[i] && sl_cls[i] == tcs_pkg::CLS_PER) anyp = 1'b1;
            if (anyp) idlew_f = 1'b1; else none_f = 1'b1;
            return;
        end
        sl_t0[nxt-1] = ticks;
        sl_s0[nxt-1] = sub;
        cur_run = nxt;
    endfunction

    function automatic longint ticks_used(int pid, logic [7:0] sub);
        longint modv, now, thn;
        modv = 65536 * SUBT;
        now = longint'(ticks) * SUBT + sub;
        thn = longint'(sl_t0[pid-1]) * SUBT + sl_s0[pid-1];
        return ((now + modv - (thn % modv)) % modv) / SUBT;
    endfunction

    // Predicts the result of one command transaction.
    function automatic tcs_pkg::t_out_item predict_step(tcs_pkg::t_in_item it);
        tcs_pkg::t_out_item r;
        int run, created;
        bit sw;
        longint sum, u;
        r = '0;
        run = cur_run;
        created = 0;
        sw = 1'b0;
        ovf_f = 1'b0; idlew_f = 1'b0; none_f = 1'b0;
        case (it.command)
            tcs_pkg::CMD_CREATE_SYS, tcs_pkg::CMD_CREATE_RR, tcs_pkg::CMD_CREATE_PER: begin
                for (int i = 0; i < NSLOT; i++)
                    if (created == 0 && !sl_used[i]) created = i + 1;
                if (created == 0) r.table_full = 1'b1;
                else begin
                    sl_used[created-1] = 1'b1;
                    if (it.command == tcs_pkg::CMD_CREATE_PER) begin
                        sl_cls[created-1] = tcs_pkg::CLS_PER;
                        sl_per[created-1] = it.task_period;
                        sl_bud[created-1] = it.task_budget;
                        sl_ph[created-1]  = it.task_phase;
                    end else if (it.command == tcs_pkg::CMD_CREATE_RR) begin
                        sl_cls[created-1] = tcs_pkg::CLS_RR;
                        enqueue(tcs_pkg::CLS_RR, created - 1);
                    end else begin
                        sl_cls[created-1] = tcs_pkg::CLS_SYS;
                        enqueue(tcs_pkg::CLS_SYS, created - 1);
                        if (class_of(run) == tcs_pkg::CLS_RR) begin
                            enqueue(tcs_pkg::CLS_RR, run - 1);
                            pick_next(it.subtick_now); sw = 1'b1;
                        end else if (class_of(run) == tcs_pkg::CLS_PER) begin
                            per_wait = run;
                            pick_next(it.subtick_now); sw = 1'b1;
                        end
                    end
                end
            end
            tcs_pkg::CMD_YIELD: if (run != 0) begin
                enqueue(class_of(run), run - 1);
                pick_next(it.subtick_now); sw = 1'b1;
            end
            tcs_pkg::CMD_TERMINATE: if (run != 0) begin
                sl_used[run-1] = 1'b0;
                cur_run = 0;
                pick_next(it.subtick_now); sw = 1'b1;
            end
            tcs_pkg::CMD_TICK: begin
                ticks = ticks + 16'd1;
                for (int i = 0; i < NSLOT; i++) begin
                    sum = longint'(ticks) + sl_ph[i];
                    if (sl_used[i] && sl_cls[i] == tcs_pkg::CLS_PER && sl_per[i] != 0
                        && sum % sl_per[i] == 0 && ticks > sl_ph[i]) begin
                        if (per_wait != 0) r.periodic_overlap = 1'b1;
                        else if (class_of(run) == tcs_pkg::CLS_PER) r.periodic_collision = 1'b1;
                        else per_wait = i + 1;
                    end
                end
                if (per_wait != 0) begin
                    enqueue(class_of(run), run - 1);
                    pick_next(it.subtick_now); sw = 1'b1;
                end else if (run != 0) begin
                    u = ticks_used(run, it.subtick_now);
                    if (u > 0) begin
                        if (class_of(run) == tcs_pkg::CLS_PER) begin
                            if (u > sl_bud[run-1]) r.budget_overrun = 1'b1;
                        end else begin
                            enqueue(class_of(run), run - 1);
                            pick_next(it.subtick_now); sw = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (cur_run == 0 && !sw) begin
            pick_next(it.subtick_now); sw = 1'b1;
        end
        r.created_pid    = created[3:0];
        r.running_pid    = cur_run[3:0];
        r.switched       = sw;
        r.queue_overflow = ovf_f;
        r.idle_waiting   = idlew_f;
        r.no_task_left   = none_f;
        r.tick_now       = ticks;
        return r;
    endfunction

    // Sends one command transaction and records its expected result.
    // Valid stays high into the next transaction unless an idle gap is taken.
    task automatic send_cmd(tcs_pkg::t_in_item it);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        expected_results.push_back(predict_step(it));
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    function automatic tcs_pkg::t_in_item mk(tcs_pkg::t_cmd c, logic [15:0] p,
                                             logic [15:0] b, logic [15:0] ph);
        tcs_pkg::t_in_item it;
        it.command = c;
        it.task_period = p;
        it.task_budget = b;
        it.task_phase = ph;
        it.subtick_now = 8'($urandom_range(0, 249));
        return it;
    endfunction

    // Output side: random stalls and the field-by-field check.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= quiet ? 1'b1 : ($urandom_range(0, 3) != 0);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with no expectation");
                failed = 1'b1;
            end else begin
                tcs_pkg::t_out_item e;
                e = expected_results.pop_front();
                if (e.created_pid !== o_out_item.created_pid) begin
                    $error("created_pid exp %0d got %0d", e.created_pid,
                           o_out_item.created_pid); failed = 1'b1; end
                if (e.running_pid !== o_out_item.running_pid) begin
                    $error("running_pid exp %0d got %0d", e.running_pid,
                           o_out_item.running_pid); failed = 1'b1; end
                if (e.switched !== o_out_item.switched) begin
                    $error("switched exp %0d got %0d", e.switched,
                           o_out_item.switched); failed = 1'b1; end
                if (e.table_full !== o_out_item.table_full) begin
                    $error("table_full exp %0d got %0d", e.table_full,
                           o_out_item.table_full); failed = 1'b1; end
                if (e.queue_overflow !== o_out_item.queue_overflow) begin
                    $error("queue_overflow exp %0d got %0d", e.queue_overflow,
                           o_out_item.queue_overflow); failed = 1'b1; end
                if (e.periodic_overlap !== o_out_item.periodic_overlap) begin
                    $error("periodic_overlap exp %0d got %0d", e.periodic_overlap,
                           o_out_item.periodic_overlap); failed = 1'b1; end
                if (e.periodic_collision !== o_out_item.periodic_collision) begin
                    $error("periodic_collision exp %0d got %0d", e.periodic_collision,
                           o_out_item.periodic_collision); failed = 1'b1; end
                if (e.budget_overrun !== o_out_item.budget_overrun) begin
                    $error("budget_overrun exp %0d got %0d", e.budget_overrun,
                           o_out_item.budget_overrun); failed = 1'b1; end
                if (e.idle_waiting !== o_out_item.idle_waiting) begin
                    $error("idle_waiting exp %0d got %0d", e.idle_waiting,
                           o_out_item.idle_waiting); failed = 1'b1; end
                if (e.no_task_left !== o_out_item.no_task_left) begin
                    $error("no_task_left exp %0d got %0d", e.no_task_left,
                           o_out_item.no_task_left); failed = 1'b1; end
                if (e.tick_now !== o_out_item.tick_now) begin
                    $error("tick_now exp %0d got %0d", e.tick_now,
                           o_out_item.tick_now); failed = 1'b1; end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL three_class_task_scheduler");
            $finish;
        end
    end

    // Directed: extremes, table full, and every command.
    task automatic test_directed();
        send_cmd(mk(tcs_pkg::CMD_YIELD, 16'd1, 16'd0, 16'd0));
        send_cmd(mk(tcs_pkg::CMD_TERMINATE, 16'd1, 16'd0, 16'd0));
        send_cmd(mk(tcs_pkg::CMD_TICK, 16'd1, 16'd0, 16'd0));
        send_cmd(mk(tcs_pkg::CMD_CREATE_PER, 16'd1, 16'd0, 16'd0));
        send_cmd(mk(tcs_pkg::CMD_CREATE_PER, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_cmd(mk(tcs_pkg::CMD_CREATE_PER, 16'd0, 16'd1, 16'd3));
        for (int i = 0; i < 5; i++) send_cmd(mk(tcs_pkg::CMD_TICK, 16'd0, 16'd0, 16'd0));
        send_cmd(mk(tcs_pkg::CMD_CREATE_RR, 16'd0, 16'd0, 16'd0));
        send_cmd(mk(tcs_pkg::CMD_CREATE_SYS, 16'd0, 16'd0, 16'd0));
        send_cmd(mk(tcs_pkg::CMD_CREATE_RR, 16'd0, 16'd0, 16'd0));
        send_cmd(mk(tcs_pkg::CMD_CREATE_SYS, 16'd0, 16'd0, 16'd0));
        send_cmd(mk(tcs_pkg::CMD_CREATE_RR, 16'd0, 16'd0, 16'd0));
        send_cmd(mk(tcs_pkg::CMD_CREATE_SYS, 16'd0, 16'd0, 16'd0));
        send_cmd(mk(tcs_pkg::t_cmd'(3'd6), 16'd0, 16'd0, 16'd0));
        send_cmd(mk(tcs_pkg::t_cmd'(3'd7), 16'd0, 16'd0, 16'd0));
        send_cmd(mk(tcs_pkg::CMD_YIELD, 16'd0, 16'd0, 16'd0));
        send_cmd(mk(tcs_pkg::CMD_TICK, 16'd0, 16'd0, 16'd0));
        for (int i = 0; i < 8; i++)
            send_cmd(mk(tcs_pkg::CMD_TERMINATE, 16'd0, 16'd0, 16'd0));
    endtask

    // Random: mostly ticks and small periods so that releases happen often.
    task automatic test_random(int n);
        tcs_pkg::t_in_item it;
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            it = mk(tcs_pkg::CMD_TICK, 16'd0, 16'd0, 16'd0);
            it.task_period = 16'($urandom);
            it.task_budget = 16'($urandom);
            it.task_phase  = 16'($urandom);
            if (k < 8) it.command = tcs_pkg::CMD_CREATE_SYS;
            else if (k < 18) it.command = tcs_pkg::CMD_CREATE_RR;
            else if (k < 28) begin
                it.command = tcs_pkg::CMD_CREATE_PER;
                if ($urandom_range(0, 4) != 0) begin
                    it.task_period = 16'($urandom_range(1, 12));
                    it.task_budget = 16'($urandom_range(0, 4));
                    it.task_phase  = 16'($urandom_range(0, 10));
                end
            end else if (k < 40) it.command = tcs_pkg::CMD_YIELD;
            else if (k < 52) it.command = tcs_pkg::CMD_TERMINATE;
            else if (k < 54) it.command = tcs_pkg::t_cmd'(3'($urandom_range(6, 7)));
            if ($urandom_range(0, 9) == 0) it.subtick_now = 8'($urandom);
            send_cmd(it);
        end
    endtask

    initial begin
        sl_used = '0;
        for (int i = 0; i < NSLOT; i++) begin
            sl_cls[i] = tcs_pkg::CLS_NONE;
            sl_per[i] = '0; sl_ph[i] = '0; sl_bud[i] = '0;
            sl_t0[i] = '0; sl_s0[i] = '0;
        end
        per_wait = 0;
        cur_run = 0;
        ticks = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1200);
        quiet = 1'b1;
        test_random(150);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (!failed && expected_results.size() == 0)
            $display("PASS three_class_task_scheduler");
        else
            $display("FAIL three_class_task_scheduler");
        $finish;
    end
endmodule

/* three_class_task_scheduler.f */
+incdir+src
src/tcs_pkg.sv
src/tcs_div.sv
src/tcs_ctrl.sv
src/tcs_dp.sv
src/three_class_task_scheduler.sv
dv/tb_top.sv
